/* rtl/lrc_pkg.sv */
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants for the line rectangle clipper
// Beat types for both channels, widths of the internal arithmetic, and the
// operand group handed to each divider lane.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int COORD_BITS = 12;
    // signed coordinate difference
    localparam int DIFF_BITS  = COORD_BITS + 1;
    // signed product and sum of two products
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    // magnitude of a numerator
    localparam int NUM_BITS   = 2 * COORD_BITS + 1;
    // one range step plus one step per quotient bit
    localparam int DIV_STEPS  = COORD_BITS + 1;
    localparam int DIV_STAGES = (DIV_STEPS + 1) / 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] line_x0;
        logic [COORD_BITS-1:0] line_y0;
        logic [COORD_BITS-1:0] line_x1;
        logic [COORD_BITS-1:0] line_y1;
        logic [COORD_BITS-1:0] box_ax;
        logic [COORD_BITS-1:0] box_ay;
        logic [COORD_BITS-1:0] box_bx;
        logic [COORD_BITS-1:0] box_by;
    } in_beat_t;

    typedef struct packed {
        logic                  valid_res;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
    } out_beat_t;

    // operands of one crossing: |num| / |den|, sign of the true quotient
    typedef struct packed {
        logic [NUM_BITS-1:0]   num_mag;
        logic [COORD_BITS-1:0] den_mag;
        logic                  neg;
    } div_op_t;

    // result of one crossing
    typedef struct packed {
        logic [COORD_BITS-1:0] quo;
        logic                  ovf;
        logic                  neg;
    } div_res_t;

endpackage

/* rtl/lrc_div.sv */
// ----------------------------------------------------------------------------
// lrc_div: pipelined restoring divider lane
// Two steps per stage: first a range step that flags quotients of
// COORD_BITS+1 bits or more, then one quotient bit per step, MSB first.
// ----------------------------------------------------------------------------
module lrc_div (
    input  logic             clk,
    input  logic             en,
    input  lrc_pkg::div_op_t op,
    output lrc_pkg::div_res_t res
);
    import lrc_pkg::*;

    logic [NUM_BITS-1:0]   r_reg [DIV_STAGES];
    logic [COORD_BITS-1:0] d_reg [DIV_STAGES];
    logic [COORD_BITS-1:0] q_reg [DIV_STAGES];
    logic                  o_reg [DIV_STAGES];
    logic                  n_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic [NUM_BITS-1:0]   r_next;
            logic [COORD_BITS-1:0] q_next;
            logic                  o_next;
            logic [NUM_BITS-1:0]   r_in;
            logic [COORD_BITS-1:0] q_in;
            logic                  o_in;
            logic [COORD_BITS-1:0] d_in;
            logic                  n_in;

            // take the previous stage, or the operands at the head
            if (s == 0)
            begin : g_head
                assign r_in = op.num_mag;
                assign q_in = '0;
                assign o_in = 1'b0;
                assign d_in = op.den_mag;
                assign n_in = op.neg;
            end
            else
            begin : g_body
                assign r_in = r_reg[s-1];
                assign q_in = q_reg[s-1];
                assign o_in = o_reg[s-1];
                assign d_in = d_reg[s-1];
                assign n_in = n_reg[s-1];
            end

            // run the two steps of this stage
            always_comb
            begin
                logic [NUM_BITS-1:0] dsh;
                int                  j;
                dsh    = '0;
                j      = 0;
                r_next = r_in;
                q_next = q_in;
                o_next = o_in;
                for (int t = 0; t < 2; t++)
                begin
                    j = 2 * s + t;
                    if (j == 0)
                    begin
                        dsh    = NUM_BITS'(d_in) << COORD_BITS;
                        o_next = (r_next >= dsh);
                    end
                    else if (j <= COORD_BITS)
                    begin
                        dsh = NUM_BITS'(d_in) << (COORD_BITS - j);
                        if (r_next >= dsh)
                        begin
                            r_next                = r_next - dsh;
                            q_next[COORD_BITS-j] = 1'b1;
                        end
                    end
                end
            end

            // advance the stage
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[s] <= r_next;
                    q_reg[s] <= q_next;
                    o_reg[s] <= o_next;
                    d_reg[s] <= d_in;
                    n_reg[s] <= n_in;
                end
            end
        end
    endgenerate

    assign res.quo = q_reg[DIV_STAGES-1];
    assign res.ovf = o_reg[DIV_STAGES-1];
    assign res.neg = n_reg[DIV_STAGES-1];

endmodule

/* rtl/line_rectangle_clip.sv */
// ----------------------------------------------------------------------------
// line_rectangle_clip: clip a line through two points to an axis-aligned box
// Returns the clipped end points, clearing valid_res when a sloped line has
// under two distinct crossings in the box; axis-parallel lines span the box.
// ----------------------------------------------------------------------------
// One beat is accepted every cycle while the output side takes results; each
// beat gives one result beat through three input stages, the pipelined divider
// lanes that work out the four crossings at two divider steps per stage, and an
// output register. The whole pipeline holds while a result waits at the output,
// so in_ready follows out_ready in that state.
module line_rectangle_clip (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lrc_pkg::in_beat_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lrc_pkg::out_beat_t out_data
);
    import lrc_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS-1:0] xmin;
        logic [COORD_BITS-1:0] xmax;
        logic [COORD_BITS-1:0] ymin;
        logic [COORD_BITS-1:0] ymax;
        logic                  dx_zero;
        logic                  dy_zero;
    } side_t;

    logic adv;

    logic                  v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic                  vd_reg [DIV_STAGES];
    side_t                 sb1_reg, sb2_reg, sb3_reg;
    side_t                 sbd_reg [DIV_STAGES];
    logic signed [DIFF_BITS-1:0] dx_reg, dy_reg, exmin_reg, exmax_reg, eymin_reg, eymax_reg;
    logic signed [DIFF_BITS-1:0] dx2_reg, dy2_reg;
    logic signed [PROD_BITS-1:0] p_ydx_reg, p_xdy_reg;
    logic signed [PROD_BITS-1:0] p_xmin_reg, p_xmax_reg, p_ymin_reg, p_ymax_reg;
    div_op_t               op_reg [4];
    div_res_t              dres [4];
    out_beat_t             out_data_reg, out_next;
    side_t                 sb1_next;

    // hold everything while a result waits
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: box bounds and differences
    always_comb
    begin
        sb1_next.x0      = in_data.line_x0;
        sb1_next.y0      = in_data.line_y0;
        sb1_next.xmin    = (in_data.box_ax < in_data.box_bx) ? in_data.box_ax : in_data.box_bx;
        sb1_next.xmax    = (in_data.box_ax < in_data.box_bx) ? in_data.box_bx : in_data.box_ax;
        sb1_next.ymin    = (in_data.box_ay < in_data.box_by) ? in_data.box_ay : in_data.box_by;
        sb1_next.ymax    = (in_data.box_ay < in_data.box_by) ? in_data.box_by : in_data.box_ay;
        sb1_next.dx_zero = (in_data.line_x0 == in_data.line_x1);
        sb1_next.dy_zero = (in_data.line_y0 == in_data.line_y1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb1_reg   <= sb1_next;
            dx_reg    <= $signed({1'b0, in_data.line_x0}) - $signed({1'b0, in_data.line_x1});
            dy_reg    <= $signed({1'b0, in_data.line_y0}) - $signed({1'b0, in_data.line_y1});
            exmin_reg <= $signed({1'b0, sb1_next.xmin}) - $signed({1'b0, in_data.line_x0});
            exmax_reg <= $signed({1'b0, sb1_next.xmax}) - $signed({1'b0, in_data.line_x0});
            eymin_reg <= $signed({1'b0, sb1_next.ymin}) - $signed({1'b0, in_data.line_y0});
            eymax_reg <= $signed({1'b0, sb1_next.ymax}) - $signed({1'b0, in_data.line_y0});
        end
    end

    // stage 2: products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb2_reg    <= sb1_reg;
            dx2_reg    <= dx_reg;
            dy2_reg    <= dy_reg;
            p_ydx_reg  <= $signed({1'b0, sb1_reg.y0}) * dx_reg;
            p_xdy_reg  <= $signed({1'b0, sb1_reg.x0}) * dy_reg;
            p_xmin_reg <= exmin_reg * dy_reg;
            p_xmax_reg <= exmax_reg * dy_reg;
            p_ymin_reg <= eymin_reg * dx_reg;
            p_ymax_reg <= eymax_reg * dx_reg;
        end
    end

    // stage 3: numerators as sign and magnitude
    function automatic div_op_t make_op(input logic signed [PROD_BITS-1:0] num,
                                        input logic signed [DIFF_BITS-1:0] den);
        div_op_t                op;
        logic [PROD_BITS-1:0]   nm;
        logic [DIFF_BITS-1:0]   dm;
        nm = num[PROD_BITS-1] ? (~num + 1'b1) : num;
        dm = den[DIFF_BITS-1] ? (~den + 1'b1) : den;
        op.num_mag = nm[NUM_BITS-1:0];
        op.den_mag = dm[COORD_BITS-1:0];
        op.neg     = num[PROD_BITS-1] ^ den[DIFF_BITS-1];
        return op;
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb3_reg   <= sb2_reg;
            op_reg[0] <= make_op(p_ydx_reg + p_xmin_reg, dx2_reg);
            op_reg[1] <= make_op(p_ydx_reg + p_xmax_reg, dx2_reg);
            op_reg[2] <= make_op(p_xdy_reg + p_ymin_reg, dy2_reg);
            op_reg[3] <= make_op(p_xdy_reg + p_ymax_reg, dy2_reg);
        end
    end

    // divider lanes, one per box edge
    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            lrc_div u_div (
                .clk (clk),
                .en  (adv),
                .op  (op_reg[g]),
                .res (dres[g])
            );
        end
    endgenerate

    // carry the side data alongside the divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sbd_reg[0] <= sb3_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                sbd_reg[i] <= sbd_reg[i-1];
            end
        end
    end

    // final stage: range checks and end point selection
    always_comb
    begin
        side_t                 sb;
        logic [3:0]            kept;
        logic [COORD_BITS-1:0] px [4];
        logic [COORD_BITS-1:0] py [4];
        logic [COORD_BITS-1:0] lo, hi;
        logic                  found, ok;
        sb   = sbd_reg[DIV_STAGES-1];
        px[0] = sb.xmin;       py[0] = dres[0].quo;
        px[1] = sb.xmax;       py[1] = dres[1].quo;
        px[2] = dres[2].quo;   py[2] = sb.ymin;
        px[3] = dres[3].quo;   py[3] = sb.ymax;
        for (int i = 0; i < 4; i++)
        begin
            lo = (i < 2) ? sb.ymin : sb.xmin;
            hi = (i < 2) ? sb.ymax : sb.xmax;
            kept[i] = !dres[i].ovf && (!dres[i].neg || dres[i].quo == '0)
                      && dres[i].quo >= lo && dres[i].quo <= hi;
        end
        out_next = '0;
        found    = 1'b0;
        ok       = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (kept[i] && !found)
            begin
                found            = 1'b1;
                out_next.start_x = px[i];
                out_next.start_y = py[i];
            end
            else if (kept[i] && (px[i] != out_next.start_x || py[i] != out_next.start_y))
            begin
                ok             = 1'b1;
                out_next.end_x = px[i];
                out_next.end_y = py[i];
            end
        end
        if (!ok)
        begin
            out_next = '0;
        end
        priority if (sb.dx_zero)
        begin
            out_next = '{1'b1, sb.x0, sb.ymin, sb.x0, sb.ymax};
        end
        else if (sb.dy_zero)
        begin
            out_next = '{1'b1, sb.xmin, sb.y0, sb.xmax, sb.y0};
        end
        else
        begin
            out_next.valid_res = ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_next;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                vd_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            vd_reg[0] <= v3_reg;
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                vd_reg[i] <= vd_reg[i-1];
            end
            out_valid_reg <= vd_reg[DIV_STAGES-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a cleared result carries zero end points
    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.valid_res) |->
        (out_data.start_x == '0 && out_data.start_y == '0 &&
         out_data.end_x == '0 && out_data.end_y == '0))
        else $error("cleared result with non-zero end points");

    // input side only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a waiting result");

    // a held result stays in place across the stall
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_data))
        else $error("waiting result changed");

endmodule

/* tb/line_rectangle_clip_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rectangle_clip_tb: self-checking bench for the line rectangle clipper
// Drives line and box beats, with random gaps outside the back-to-back test,
// works out each beat's clipped end points and compares every result in order.
// ----------------------------------------------------------------------------
module line_rectangle_clip_tb;
    import lrc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY     = 11;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    out_beat_t clip_q[$];
    int        fail_count;
    int        cycle_count;
    bit        gaps_on;

    line_rectangle_clip uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // work out the clipped end points of one beat
    function automatic out_beat_t clip_line(in_beat_t b);
        out_beat_t r;
        longint x0, y0, x1, y1, xmin, xmax, ymin, ymax, dx, dy, c;
        longint kx[4];
        longint ky[4];
        int     n;
        bit     ok;
        longint sx, sy, ex, ey;
        x0 = b.line_x0; y0 = b.line_y0; x1 = b.line_x1; y1 = b.line_y1;
        xmin = (b.box_ax < b.box_bx) ? b.box_ax : b.box_bx;
        xmax = (b.box_ax < b.box_bx) ? b.box_bx : b.box_ax;
        ymin = (b.box_ay < b.box_by) ? b.box_ay : b.box_by;
        ymax = (b.box_ay < b.box_by) ? b.box_by : b.box_ay;
        dx = x0 - x1;
        dy = y0 - y1;
        n = 0; ok = 0; sx = 0; sy = 0; ex = 0; ey = 0;
        if (dx == 0)
        begin
            ok = 1; sx = x0; sy = ymin; ex = x0; ey = ymax;
        end
        else if (dy == 0)
        begin
            ok = 1; sx = xmin; sy = y0; ex = xmax; ey = y0;
        end
        else
        begin
            // SV division on longint truncates toward zero
            c = (y0 * dx + (xmin - x0) * dy) / dx;
            if (c >= ymin && c <= ymax) begin kx[n] = xmin; ky[n] = c; n++; end
            c = (y0 * dx + (xmax - x0) * dy) / dx;
            if (c >= ymin && c <= ymax) begin kx[n] = xmax; ky[n] = c; n++; end
            c = (x0 * dy + (ymin - y0) * dx) / dy;
            if (c >= xmin && c <= xmax) begin kx[n] = c; ky[n] = ymin; n++; end
            c = (x0 * dy + (ymax - y0) * dx) / dy;
            if (c >= xmin && c <= xmax) begin kx[n] = c; ky[n] = ymax; n++; end
            if (n >= 2)
            begin
                sx = kx[0]; sy = ky[0];
                for (int i = 1; i < n; i++)
                    if (kx[i] != sx || ky[i] != sy)
                    begin
                        ok = 1; ex = kx[i]; ey = ky[i];
                    end
            end
        end
        r.valid_res = ok;
        r.start_x   = ok ? sx[COORD_BITS-1:0] : '0;
        r.start_y   = ok ? sy[COORD_BITS-1:0] : '0;
        r.end_x     = ok ? ex[COORD_BITS-1:0] : '0;
        r.end_y     = ok ? ey[COORD_BITS-1:0] : '0;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (t=%0t)", what, got, want, $realtime);
        fail_count++;
    endtask

    // send one beat, with an optional gap in front
    task automatic send_beat(in_beat_t b);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        clip_q = {clip_q, clip_line(b)};
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (clip_q.size() != 0) @(posedge clk);
    endtask

    function automatic in_beat_t rand_beat();
        in_beat_t b;
        b = in_beat_t'({$urandom, $urandom, $urandom});
        return b;
    endfunction

    function automatic in_beat_t mk(int x0, int y0, int x1, int y1,
                                    int ax, int ay, int bx, int by);
        in_beat_t b;
        b.line_x0 = COORD_BITS'(x0); b.line_y0 = COORD_BITS'(y0);
        b.line_x1 = COORD_BITS'(x1); b.line_y1 = COORD_BITS'(y1);
        b.box_ax = COORD_BITS'(ax); b.box_ay = COORD_BITS'(ay);
        b.box_bx = COORD_BITS'(bx); b.box_by = COORD_BITS'(by);
        return b;
    endfunction

    // result checker and output stall generator
    initial
    begin : result_check
        out_beat_t want;
        int        stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (clip_q.size() == 0)
                begin
                    report("unexpected beat", 1, 0);
                end
                else
                begin
                    want = clip_q.pop_front();
                    if (out_data.valid_res !== want.valid_res)
                        report("valid_res", out_data.valid_res, want.valid_res);
                    if (out_data.start_x !== want.start_x)
                        report("start_x", out_data.start_x, want.start_x);
                    if (out_data.start_y !== want.start_y)
                        report("start_y", out_data.start_y, want.start_y);
                    if (out_data.end_x !== want.end_x)
                        report("end_x", out_data.end_x, want.end_x);
                    if (out_data.end_y !== want.end_y)
                        report("end_y", out_data.end_y, want.end_y);
                end
            end
            // hold ready low for a burst now and then
            if (stall > 0)
            begin
                stall--;
                out_ready <= (stall == 0);
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 15);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_beat(mk(0, 0, 4095, 4095, 0, 0, 4095, 4095));
        send_beat(mk(4095, 0, 0, 4095, 4095, 4095, 0, 0));
        send_beat(mk(100, 100, 100, 100, 10, 20, 300, 400));   // coincident points
        send_beat(mk(50, 10, 50, 900, 300, 400, 10, 20));      // vertical line
        send_beat(mk(10, 77, 900, 77, 300, 400, 10, 20));      // horizontal line
        send_beat(mk(4000, 5, 4000, 6, 0, 0, 100, 100));       // vertical, misses box
        send_beat(mk(0, 4095, 4095, 4095, 5, 5, 5, 5));        // horizontal, flat box
        send_beat(mk(0, 0, 1, 1, 200, 0, 300, 10));            // misses box
        send_beat(mk(0, 0, 1, 1, 5, 5, 5, 5));                 // touches one corner
        send_beat(mk(0, 10, 10, 0, 0, 0, 10, 10));             // corner crossings
        send_beat(mk(0, 0, 3, 7, 1, 1, 4000, 4000));           // truncation
        send_beat(mk(4095, 4095, 0, 1, 0, 0, 4095, 4095));
        send_beat(mk(1, 0, 0, 4095, 0, 0, 4095, 4095));        // steep
        send_beat(mk(0, 1, 4095, 0, 0, 0, 4095, 4095));        // shallow
        send_beat(mk(2048, 2048, 2049, 2047, 0, 4095, 4095, 0));
        send_beat(mk(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095));
        send_beat(mk(0, 0, 0, 0, 0, 0, 0, 0));
        send_beat(mk(4095, 0, 4094, 4095, 0, 0, 4095, 4095));
        drain();
    endtask

    task automatic test_random_lines();
        in_beat_t b;
        for (int i = 0; i < 500; i++)
        begin
            b = rand_beat();
            // mostly lines that cross a sizeable box
            if ($urandom_range(0, 3) != 0)
            begin
                b.box_ax = COORD_BITS'($urandom_range(0, 1500));
                b.box_bx = COORD_BITS'($urandom_range(2500, 4095));
                b.box_ay = COORD_BITS'($urandom_range(0, 1500));
                b.box_by = COORD_BITS'($urandom_range(2500, 4095));
                if ($urandom_range(0, 1))
                    {b.box_ax, b.box_bx} = {b.box_bx, b.box_ax};
            end
            case ($urandom_range(0, 9))
                0: b.line_x1 = b.line_x0;
                1: b.line_y1 = b.line_y0;
                2: b.line_x1 = b.line_x0 + 1'b1;
                default: ;
            endcase
            send_beat(b);
            // let the pipeline empty once
            if (i == 250)
                drain();
        end
        drain();
    endtask

    task automatic test_back_to_back();
        gaps_on = 0;
        for (int i = 0; i < 230; i++)
            send_beat(rand_beat());
        drain();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        fail_count = 0;
        gaps_on    = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_lines();
        test_back_to_back();
        repeat (LATENCY * 4) @(posedge clk);
        if (fail_count == 0 && clip_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
